// ===== rtl/cau_pkg.sv =====
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_CMP = 3'd4
	} cmd_t;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

endpackage

// ===== rtl/cau_if.sv =====
interface cau_in_if #(parameter int DW = 16) ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           cmd;
	logic signed [DW-1:0] first_re;
	logic signed [DW-1:0] first_im;
	logic signed [DW-1:0] second_re;
	logic signed [DW-1:0] second_im;
	modport source (output valid, cmd, first_re, first_im, second_re, second_im, input ready);
	modport sink (input valid, cmd, first_re, first_im, second_re, second_im, output ready);
endinterface

interface cau_out_if #(parameter int DW = 16) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] result_re;
	logic signed [DW-1:0] result_im;
	logic [1:0]           order;
	logic [1:0]           status;
	modport source (output valid, result_re, result_im, order, status, input ready);
	modport sink (input valid, result_re, result_im, order, status, output ready);
endinterface

// ===== rtl/cau_div.sv =====
// pipelined restoring divider, one quotient bit per stage, unsigned
module cau_div import cau_pkg::*; #(
	parameter int NW = 34,
	parameter int QW = 34,
	parameter int TW = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	// remainder needs NW+1 bits; numerator is pre-shifted so that QW bits come out
	localparam int RW = NW + 1;
	localparam int PW = NW + QW;

	logic [RW-1:0] rem_s [QW+1];
	logic [PW-1:0] num_s [QW+1];
	logic [NW-1:0] den_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [TW-1:0] tag_s [QW+1];

	always_comb begin
		rem_s[0] = '0;
		num_s[0] = {{QW{1'b0}}, num} << QW;
		den_s[0] = den;
		q_s[0]   = '0;
		tag_s[0] = tag_in;
	end

	for (genvar i = 0; i < QW; i++) begin : g_st
		logic [RW-1:0] trial;
		logic [RW-1:0] diff;
		always_comb begin
			trial = {rem_s[i][RW-2:0], num_s[i][PW-1]};
			diff  = trial - {1'b0, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= diff[RW-1] ? trial : diff;
				num_s[i+1] <= num_s[i] << 1;
				den_s[i+1] <= den_s[i];
				q_s[i+1]   <= {q_s[i][QW-2:0], ~diff[RW-1]};
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign quo     = q_s[QW];
	assign tag_out = tag_s[QW];
endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// channel | dir | payload
// in      | in  | cmd, first_re, first_im, second_re, second_im
// out     | out | result_re, result_im, order, status
// one transaction per cycle unless the output stalls; the default format is q8.8
// the divider's bit-per-stage chain sets the depth, every stage advances together
// a stall on the output freezes the whole pipeline; nothing is lost or repeated
// reset clears only the stage valid bits
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	cau_in_if.sink    in_ch,
	cau_out_if.source out_ch
);
	localparam int DW  = DATA_WIDTH;
	localparam int MW  = DW;             // magnitude width
	localparam int PW  = 2 * MW;         // product width
	localparam int SW  = PW + 1;         // sum of two products
	localparam int QW  = SW + FRAC_BITS + 1; // quotient with one rounding bit
	localparam int TW  = 3 + 2 + 1;      // cmd, signs, zero-den
	localparam int LAT = QW + 4;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = ~vld_q[LAT-1] | out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	// stage 1: magnitudes and signs
	logic [2:0]    cmd_s1;
	logic          ns_s1 [4];
	logic [MW-1:0] mg_s1 [4];
	logic signed [DW-1:0] op [4];
	assign op[0] = in_ch.first_re;
	assign op[1] = in_ch.first_im;
	assign op[2] = in_ch.second_re;
	assign op[3] = in_ch.second_im;
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.cmd;
			for (int k = 0; k < 4; k++) begin
				ns_s1[k] <= op[k][DW-1];
				mg_s1[k] <= op[k][DW-1] ? MW'(-op[k]) : MW'(op[k]);
			end
		end
	end

	// stage 2: products, squares, and add/sub sums
	logic [2:0]    cmd_s2;
	logic signed [DW+1:0] sre_s2, sim_s2;
	logic signed [SW:0] p_s2 [4]; // arbr, aibi, arbi, aibr signed
	logic [PW-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2;
	logic signed [SW:0] ps [4];
	always_comb begin
		ps[0] = (ns_s1[0] ^ ns_s1[2]) ? -(SW+1)'(mg_s1[0]*mg_s1[2]) : (SW+1)'(mg_s1[0]*mg_s1[2]);
		ps[1] = (ns_s1[1] ^ ns_s1[3]) ? -(SW+1)'(mg_s1[1]*mg_s1[3]) : (SW+1)'(mg_s1[1]*mg_s1[3]);
		ps[2] = (ns_s1[0] ^ ns_s1[3]) ? -(SW+1)'(mg_s1[0]*mg_s1[3]) : (SW+1)'(mg_s1[0]*mg_s1[3]);
		ps[3] = (ns_s1[1] ^ ns_s1[2]) ? -(SW+1)'(mg_s1[1]*mg_s1[2]) : (SW+1)'(mg_s1[1]*mg_s1[2]);
	end
	logic signed [DW+1:0] sa [4];
	always_comb for (int k = 0; k < 4; k++)
		sa[k] = ns_s1[k] ? -$signed({2'b00, mg_s1[k]}) : $signed({2'b00, mg_s1[k]});
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			for (int k = 0; k < 4; k++) p_s2[k] <= ps[k];
			sre_s2 <= (cmd_s1 == CMD_SUB) ? sa[0] - sa[2] : sa[0] + sa[2];
			sim_s2 <= (cmd_s1 == CMD_SUB) ? sa[1] - sa[3] : sa[1] + sa[3];
			m1a_s2 <= mg_s1[0] * mg_s1[0];
			m1b_s2 <= mg_s1[1] * mg_s1[1];
			m2a_s2 <= mg_s1[2] * mg_s1[2];
			m2b_s2 <= mg_s1[3] * mg_s1[3];
		end
	end

	// stage 3: sums
	logic [2:0]    cmd_s3;
	logic signed [DW+1:0] sre_s3, sim_s3;
	logic signed [SW:0] mre_s3, mim_s3, dre_s3, dim_s3;
	logic [SW-1:0] m1_s3, m2_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			sre_s3 <= sre_s2;
			sim_s3 <= sim_s2;
			mre_s3 <= p_s2[0] - p_s2[1];
			mim_s3 <= p_s2[2] + p_s2[3];
			dre_s3 <= p_s2[0] + p_s2[1];
			dim_s3 <= p_s2[3] - p_s2[2];
			m1_s3  <= SW'(m1a_s2) + SW'(m1b_s2);
			m2_s3  <= SW'(m2a_s2) + SW'(m2b_s2);
		end
	end

	// stage 4: non-divide results, divider operands
	typedef struct packed {
		logic [2:0] cmd;
		logic       nre;
		logic       nim;
		logic       dz;
	} dtag_t;
	localparam logic signed [SW+1:0] MAXV = (SW+2)'((64'd1 << (DW-1)) - 1);
	localparam logic signed [SW+1:0] MINV = -(SW+2)'(64'd1 << (DW-1));
	function automatic logic [DW:0] sat_f(input logic signed [SW+1:0] v);
		if (v > MAXV) return {1'b1, MAXV[DW-1:0]};
		if (v < MINV) return {1'b1, MINV[DW-1:0]};
		return {1'b0, v[DW-1:0]};
	endfunction
	function automatic logic signed [SW+1:0] rnd_f(input logic signed [SW:0] v);
		logic [SW:0] m;
		m = v[SW] ? -v : v;
		m = (m + ((SW+1)'(1) << FRAC_BITS >> 1)) >> FRAC_BITS;
		return v[SW] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction
	logic [DW:0] ar, ai;
	logic [DW-1:0] fre_s4, fim_s4;
	logic [1:0]    ord_s4, st_s4;
	logic [SW-1:0] nre_d, nim_d;
	always_comb begin
		ar = '0; ai = '0;
		unique case (cmd_s3)
			CMD_ADD, CMD_SUB: begin
				ar = sat_f((SW+2)'(sre_s3));
				ai = sat_f((SW+2)'(sim_s3));
			end
			CMD_MUL: begin
				ar = sat_f(rnd_f(mre_s3));
				ai = sat_f(rnd_f(mim_s3));
			end
			default: ;
		endcase
		nre_d = dre_s3[SW] ? SW'(-dre_s3) : SW'(dre_s3);
		nim_d = dim_s3[SW] ? SW'(-dim_s3) : SW'(dim_s3);
	end
	dtag_t tg_in, tg_out;
	assign tg_in = '{cmd: cmd_s3, nre: dre_s3[SW], nim: dim_s3[SW], dz: (m2_s3 == '0)};
	always_ff @(posedge clk) begin
		if (en) begin
			fre_s4 <= ar[DW-1:0];
			fim_s4 <= ai[DW-1:0];
			st_s4  <= (ar[DW] | ai[DW]) ? ST_SAT : ST_OK;
			ord_s4 <= (cmd_s3 != CMD_CMP) ? ORD_LESS :
				(m1_s3 < m2_s3) ? ORD_LESS : (m1_s3 == m2_s3) ? ORD_EQUAL : ORD_GREATER;
		end
	end

	// divider: n * 2^(FRAC+1) / d, then round by the extra bit
	logic [QW-1:0] qre, qim;
	logic [TW-1:0] t1, t2;
	cau_div #(.NW(SW + FRAC_BITS + 1), .QW(QW), .TW(TW)) u_dre (
		.clk, .en,
		.num({nre_d, {(FRAC_BITS+1){1'b0}}}), .den({{(FRAC_BITS+1){1'b0}}, m2_s3}),
		.tag_in(tg_in), .quo(qre), .tag_out(t1));
	cau_div #(.NW(SW + FRAC_BITS + 1), .QW(QW), .TW(TW)) u_dim (
		.clk, .en,
		.num({nim_d, {(FRAC_BITS+1){1'b0}}}), .den({{(FRAC_BITS+1){1'b0}}, m2_s3}),
		.tag_in(tg_in), .quo(qim), .tag_out(t2));
	assign tg_out = dtag_t'(t1);

	// delay line for the non-divide results alongside the divider
	logic [2*DW+3:0] dl_q [QW-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= {fre_s4, fim_s4, ord_s4, st_s4};
			for (int k = 1; k < QW-1; k++) dl_q[k] <= dl_q[k-1];
		end
	end
	// the stage 4 register plus the delay line match the divider chain, so al lines up with the tag
	logic [2*DW+3:0] al;
	assign al = dl_q[QW-2];

	// final stage
	logic [QW:0] rq_re, rq_im;
	logic signed [QW+1:0] vre, vim;
	logic [DW:0] dr, di;
	always_comb begin
		rq_re = ({1'b0, qre} + (QW+1)'(1)) >> 1;
		rq_im = ({1'b0, qim} + (QW+1)'(1)) >> 1;
		vre = tg_out.nre ? -$signed({1'b0, rq_re}) : $signed({1'b0, rq_re});
		vim = tg_out.nim ? -$signed({1'b0, rq_im}) : $signed({1'b0, rq_im});
		dr = (vre > (QW+2)'(MAXV)) ? {1'b1, MAXV[DW-1:0]} :
			(vre < (QW+2)'(MINV)) ? {1'b1, MINV[DW-1:0]} : {1'b0, vre[DW-1:0]};
		di = (vim > (QW+2)'(MAXV)) ? {1'b1, MAXV[DW-1:0]} :
			(vim < (QW+2)'(MINV)) ? {1'b1, MINV[DW-1:0]} : {1'b0, vim[DW-1:0]};
	end
	logic [DW-1:0] ore_s5, oim_s5;
	logic [1:0]    oord_s5, ost_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			if (tg_out.cmd == CMD_DIV) begin
				ore_s5  <= tg_out.dz ? '0 : dr[DW-1:0];
				oim_s5  <= tg_out.dz ? '0 : di[DW-1:0];
				oord_s5 <= ORD_LESS;
				ost_s5  <= tg_out.dz ? ST_DIV0 : ((dr[DW] | di[DW]) ? ST_SAT : ST_OK);
			end else begin
				{ore_s5, oim_s5, oord_s5, ost_s5} <= al;
			end
		end
	end
	assign out_ch.valid     = vld_q[LAT-1];
	assign out_ch.result_re = ore_s5;
	assign out_ch.result_im = oim_s5;
	assign out_ch.order     = oord_s5;
	assign out_ch.status    = ost_s5;

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_re))
		else $error("output lost under stall");
	a_ord: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.order != ORD_LESS |-> out_ch.result_re == '0)
		else $error("compare gave nonzero result");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("ready low with empty output");
	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-2] |-> t1 == t2)
		else $error("divider tags differ");
endmodule

// ===== sim/complex_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int DW = 16;
	localparam int FB = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic [1:0]    order;
		logic [1:0]    status;
	} cresult_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int cycles = 0;
	int src_idle = 0;
	int snk_idle = 0;
	cresult_t expected_results[$];

	cau_in_if  #(.DW(DW)) in_ch ();
	cau_out_if #(.DW(DW)) out_ch ();

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.first_re = '0;
		in_ch.first_im = '0;
		in_ch.second_re = '0;
		in_ch.second_im = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ch.ready <= ($urandom_range(99) >= snk_idle);
	end

	function automatic logic [DW-1:0] clip(input longint v, inout logic sat);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DW - 1)) - 1;
		lo = -(longint'(1) <<< (DW - 1));
		if (v > hi) begin
			sat = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic longint round_shift(input longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) <<< (FB - 1))) >>> FB;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint quotient(input longint n, input longint d);
		longint m;
		longint q;
		longint r;
		m = (n < 0) ? -n : n;
		q = m / d;
		if (q > (longint'(1) <<< 32))
			q = longint'(1) <<< 40;
		else begin
			r = m % d;
			q = q <<< FB;
			r = r <<< FB;
			q = q + r / d;
			r = r % d;
			if (2 * r >= d)
				q = q + 1;
		end
		return (n < 0) ? -q : q;
	endfunction

	function automatic cresult_t complex_predict(input logic [2:0] op, input logic signed [DW-1:0] ar,
			input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
			input logic signed [DW-1:0] bi);
		cresult_t r;
		logic sat;
		longint a;
		longint b;
		longint m1;
		longint m2;
		r = '0;
		sat = 1'b0;
		m1 = longint'(ar) * ar + longint'(ai) * ai;
		m2 = longint'(br) * br + longint'(bi) * bi;
		case (op)
			CMD_ADD, CMD_SUB: begin
				a = (op == CMD_ADD) ? longint'(ar) + br : longint'(ar) - br;
				b = (op == CMD_ADD) ? longint'(ai) + bi : longint'(ai) - bi;
				r.re = clip(a, sat);
				r.im = clip(b, sat);
				r.status = sat ? ST_SAT : ST_OK;
			end
			CMD_MUL: begin
				a = round_shift(longint'(ar) * br - longint'(ai) * bi);
				b = round_shift(longint'(ar) * bi + longint'(ai) * br);
				r.re = clip(a, sat);
				r.im = clip(b, sat);
				r.status = sat ? ST_SAT : ST_OK;
			end
			CMD_DIV: begin
				if (m2 == 0)
					r.status = ST_DIV0;
				else begin
					a = quotient(longint'(ar) * br + longint'(ai) * bi, m2);
					b = quotient(longint'(br) * ai - longint'(bi) * ar, m2);
					r.re = clip(a, sat);
					r.im = clip(b, sat);
					r.status = sat ? ST_SAT : ST_OK;
				end
			end
			CMD_CMP: r.order = (m1 < m2) ? ORD_LESS : ((m1 == m2) ? ORD_EQUAL : ORD_GREATER);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cresult_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_ch.result_re, '0);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.result_re !== want.re)
					report_mismatch("result_re", out_ch.result_re, want.re);
				if (out_ch.result_im !== want.im)
					report_mismatch("result_im", out_ch.result_im, want.im);
				if (out_ch.order !== want.order)
					report_mismatch("order", DW'(out_ch.order), DW'(want.order));
				if (out_ch.status !== want.status)
					report_mismatch("status", DW'(out_ch.status), DW'(want.status));
			end
		end
	end

	task automatic send_operands(input logic [2:0] op, input logic [DW-1:0] ar,
			input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= op;
		in_ch.first_re <= ar;
		in_ch.first_im <= ai;
		in_ch.second_re <= br;
		in_ch.second_im <= bi;
		do @(posedge clk); while (!in_ch.ready);
		expected_results.push_back(complex_predict(op, ar, ai, br, bi));
	endtask

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3: return DW'($urandom_range(1023)) - 16'd512;
			default: return DW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [DW-1:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		for (int op = 0; op < 8; op++)
			send_operands(op[2:0], ext[op % 4], ext[(op + 1) % 4], ext[(op + 2) % 4],
				ext[(op + 3) % 4]);
		send_operands(CMD_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		send_operands(CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_operands(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send_operands(CMD_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
		send_operands(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_operands(CMD_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
		send_operands(CMD_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
		send_operands(CMD_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
		send_operands(CMD_CMP, 16'h0300, 16'h0400, 16'h0500, 16'h0000);
		send_operands(CMD_CMP, 16'h0100, 16'h0000, 16'h0000, 16'h0200);
		send_operands(CMD_CMP, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
	endtask

	task automatic test_random(input int count, input int sidle, input int ridle);
		logic [2:0] op;
		src_idle = sidle;
		snk_idle = ridle;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
			send_operands(op, pick_value(), pick_value(), pick_value(), pick_value());
			if (i == count / 2) begin
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (expected_results.size() != 0);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 20, 59);
		test_random(300, 59, 20);
		test_random(300, 0, 0);
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
